/* src/ttsc_pkg.sv */
package ttsc_pkg;

    // list geometry
    localparam int ROWS_PER_PAGE = 8;
    localparam int LIST_TOP_Y    = 96;
    localparam int ROW_PITCH     = 56;

    // reciprocals for the constant divisions, exact over the numerator width
    localparam int PAGE_SHIFT = 16;
    localparam int PAGE_RECIP = (2 ** PAGE_SHIFT + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE;
    localparam int ROW_SHIFT  = 22;
    localparam int ROW_RECIP  = (2 ** ROW_SHIFT + ROW_PITCH - 1) / ROW_PITCH;

    // screen regions
    localparam logic [11:0] EDGE_MIN     = 12'd12;
    localparam logic [11:0] SCREEN_X_MAX = 12'd799;
    localparam logic [11:0] SCREEN_Y_MAX = 12'd587;
    localparam logic [11:0] OPEN_X_MIN   = 12'd30;
    localparam logic [11:0] OPEN_X_MAX   = 12'd630;
    localparam logic [11:0] OPEN_Y_MAX   = 12'd80;
    localparam logic [11:0] CTRL_X_MIN   = 12'd698;
    localparam logic [11:0] CTRL_X_SPLIT = 12'd744;
    localparam logic [11:0] CTRL_X_END   = 12'd790;
    localparam logic [11:0] CTRL_Y_MIN   = 12'd538;
    localparam logic [11:0] CTRL_Y_END   = 12'd584;
    localparam logic [11:0] ROW_X_MAX    = 12'd787;
    localparam logic [7:0]  CTRL_MIN_CNT = 8'd3;

    // gesture limits
    localparam logic [31:0] DUR_MIN        = 32'd30;
    localparam logic [31:0] DUR_MAX        = 32'd2000;
    localparam logic [31:0] TAP_DUR_MAX    = 32'd700;
    localparam logic [11:0] SWIPE_MIN      = 12'd45;
    localparam logic [12:0] TAP_TRAVEL_MAX = 13'd12;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_OPEN   = 3'd1,
        ACT_NEXT   = 3'd2,
        ACT_PREV   = 3'd3,
        ACT_SELECT = 3'd4
    } t_action;

    typedef struct packed {
        logic [3:0]  contacts;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [31:0] time_ms;
        logic        overview_mode;
        logic [7:0]  page_number;
        logic [7:0]  entry_count;
    } t_sample;

    typedef struct packed {
        logic        pressed;
        logic        aborted;
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [11:0] latest_x;
        logic [11:0] latest_y;
        logic [31:0] press_time;
        logic [12:0] peak_travel;
    } t_gesture;

    function automatic logic [11:0] abs_diff(input logic [11:0] a, input logic [11:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // (count - 1) / ROWS_PER_PAGE, or 0 for an empty list
    function automatic logic [7:0] final_page(input logic [7:0] count);
        logic [24:0] prod;
        prod = 25'(count - 8'd1) * 25'(PAGE_RECIP);
        return (count == 8'd0) ? 8'd0 : prod[PAGE_SHIFT +: 8];
    endfunction

endpackage

/* src/ttsc_intf.sv */
interface ttsc_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  contacts;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [31:0] time_ms;
    logic        overview_mode;
    logic [7:0]  page_number;
    logic [7:0]  entry_count;

    modport source (
        output valid, contacts, pos_x, pos_y, time_ms, overview_mode, page_number,
               entry_count,
        input  ready
    );
    modport sink (
        input  valid, contacts, pos_x, pos_y, time_ms, overview_mode, page_number,
               entry_count,
        output ready
    );
endinterface

interface ttsc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] action_kind;
    logic [7:0] entry_index;

    modport source (output valid, action_kind, entry_index, input ready);
    modport sink (input valid, action_kind, entry_index, output ready);
endinterface

/* src/ttsc_tracker.sv */
module ttsc_tracker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  ttsc_pkg::t_sample  i_sample,
    output ttsc_pkg::t_gesture o_gesture
);
    import ttsc_pkg::*;

    t_gesture    r_gest;
    t_gesture    n_gest;
    logic        w_new_press;
    logic [11:0] w_org_x;
    logic [11:0] w_org_y;
    logic [12:0] w_peak;
    logic [12:0] w_travel;

    assign w_new_press = (i_sample.contacts != 4'd0) && !r_gest.pressed;
    assign w_org_x     = w_new_press ? i_sample.pos_x : r_gest.origin_x;
    assign w_org_y     = w_new_press ? i_sample.pos_y : r_gest.origin_y;
    assign w_peak      = w_new_press ? 13'd0 : r_gest.peak_travel;
    assign w_travel    = 13'(abs_diff(i_sample.pos_x, w_org_x))
                       + 13'(abs_diff(i_sample.pos_y, w_org_y));

    always_comb begin
        n_gest = r_gest;
        if (i_en) begin
            if (i_sample.contacts != 4'd0) begin
                n_gest.pressed = 1'b1;
                if (w_new_press) begin
                    n_gest.aborted    = 1'b0;
                    n_gest.origin_x   = i_sample.pos_x;
                    n_gest.origin_y   = i_sample.pos_y;
                    n_gest.press_time = i_sample.time_ms;
                end
                if (i_sample.contacts != 4'd1) begin
                    n_gest.aborted = 1'b1;
                end
                n_gest.latest_x    = i_sample.pos_x;
                n_gest.latest_y    = i_sample.pos_y;
                n_gest.peak_travel = (w_travel > w_peak) ? w_travel : w_peak;
            end else begin
                n_gest.pressed = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gest <= '0;
        end else begin
            r_gest <= n_gest;
        end
    end

    assign o_gesture = r_gest;

endmodule

/* src/ttsc_locate.sv */
module ttsc_locate (
    input  logic [11:0]       i_x,
    input  logic [11:0]       i_y,
    input  logic              i_overview,
    input  logic [7:0]        i_page,
    input  logic [7:0]        i_count,
    input  logic [7:0]        i_last_page,
    output ttsc_pkg::t_action o_kind,
    output logic [7:0]        o_index
);
    import ttsc_pkg::*;

    logic [11:0] w_dy;
    logic [34:0] w_row_prod;
    logic [11:0] w_row;
    logic [13:0] w_index;
    logic        w_on_screen;
    logic        w_in_ctrl;

    assign w_dy       = i_y - 12'(LIST_TOP_Y);
    assign w_row_prod = 35'(w_dy) * 35'(ROW_RECIP);
    assign w_row      = w_row_prod[ROW_SHIFT +: 12];
    assign w_index    = 14'(i_page) * 14'(ROWS_PER_PAGE) + 14'(w_row);

    assign w_on_screen = (i_x >= EDGE_MIN) && (i_x <= SCREEN_X_MAX)
                      && (i_y >= EDGE_MIN) && (i_y <= SCREEN_Y_MAX);
    assign w_in_ctrl   = (i_count > CTRL_MIN_CNT) && (i_x >= CTRL_X_MIN) && (i_x < CTRL_X_END)
                      && (i_y >= CTRL_Y_MIN) && (i_y < CTRL_Y_END);

    always_comb begin
        o_kind  = ACT_NONE;
        o_index = 8'd0;
        if (!w_on_screen) begin
            o_kind = ACT_NONE;
        end else if (!i_overview) begin
            if (i_x >= OPEN_X_MIN && i_x <= OPEN_X_MAX && i_y <= OPEN_Y_MAX
                && i_count != 8'd0) begin
                o_kind = ACT_OPEN;
            end
        end else if (i_page > i_last_page) begin
            o_kind = ACT_NONE;
        end else if (w_in_ctrl) begin
            // page control: next on the left half, previous on the right
            if (i_x < CTRL_X_SPLIT && i_page < i_last_page) begin
                o_kind = ACT_NEXT;
            end
            if (i_x >= CTRL_X_SPLIT && i_page != 8'd0) begin
                o_kind = ACT_PREV;
            end
        end else if (i_x <= ROW_X_MAX && i_y >= 12'(LIST_TOP_Y)) begin
            if (w_row < 12'(ROWS_PER_PAGE) && w_index < 14'(i_count)) begin
                o_kind  = ACT_SELECT;
                o_index = w_index[7:0];
            end
        end
    end

endmodule

/* src/ttsc_classify.sv */
module ttsc_classify (
    input  ttsc_pkg::t_sample  i_sample,
    input  ttsc_pkg::t_gesture i_gesture,
    output ttsc_pkg::t_action  o_kind,
    output logic [7:0]         o_index
);
    import ttsc_pkg::*;

    logic [31:0] w_dur;
    logic [11:0] w_adx;
    logic [11:0] w_ady;
    logic [7:0]  w_last;
    logic        w_release;
    logic        w_valid_dur;
    logic        w_swipe;
    logic        w_tap;
    t_action     w_loc_kind;
    logic [7:0]  w_loc_index;

    assign w_dur  = i_sample.time_ms - i_gesture.press_time;
    assign w_adx  = abs_diff(i_gesture.latest_x, i_gesture.origin_x);
    assign w_ady  = abs_diff(i_gesture.latest_y, i_gesture.origin_y);
    assign w_last = final_page(i_sample.entry_count);

    assign w_release   = (i_sample.contacts == 4'd0) && i_gesture.pressed;
    assign w_valid_dur = !i_gesture.aborted && (w_dur >= DUR_MIN) && (w_dur <= DUR_MAX);
    assign w_swipe     = i_sample.overview_mode && (w_ady >= SWIPE_MIN)
                      && (13'(w_ady) > {w_adx, 1'b0});
    assign w_tap       = (i_gesture.peak_travel <= TAP_TRAVEL_MAX) && (w_dur <= TAP_DUR_MAX);

    ttsc_locate u_locate (
        .i_x        (i_gesture.origin_x),
        .i_y        (i_gesture.origin_y),
        .i_overview (i_sample.overview_mode),
        .i_page     (i_sample.page_number),
        .i_count    (i_sample.entry_count),
        .i_last_page(w_last),
        .o_kind     (w_loc_kind),
        .o_index    (w_loc_index)
    );

    always_comb begin
        o_kind  = ACT_NONE;
        o_index = 8'd0;
        if (w_release && w_valid_dur) begin
            if (w_swipe) begin
                // a swipe with no page to turn gives nothing, no tap fallback
                if (i_gesture.latest_y < i_gesture.origin_y
                    && i_sample.page_number < w_last) begin
                    o_kind = ACT_NEXT;
                end
                if (i_gesture.latest_y > i_gesture.origin_y
                    && i_sample.page_number != 8'd0) begin
                    o_kind = ACT_PREV;
                end
            end else if (w_tap) begin
                o_kind  = w_loc_kind;
                o_index = w_loc_index;
            end
        end
    end

endmodule

/* src/touch_tap_swipe_classifier_core.sv */
// Touch tap and swipe classifier. Every touch sample item on i_in gives exactly one
// result item on o_out, in order; the action is non-none only on the release sample of
// a single-contact gesture. One item is accepted per clock cycle, sustained while results are taken.
// Each accepted item passes through the input register, then the result register, which drives
// o_out; an item waits in the input register while a result is held back. The gesture state is
// updated in the same cycle that classifies the sample, so consecutive samples follow each
// other without gaps; the result register decouples the output, and i_in stalls only when a
// result is held back by o_out.ready.
module touch_tap_swipe_classifier_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ttsc_in_if.sink         i_in,
    ttsc_out_if.source      o_out
);
    import ttsc_pkg::*;

    logic       r_in_valid;
    t_sample    r_in;
    logic       r_out_valid;
    t_action    r_kind;
    logic [7:0] r_index;
    logic       w_advance;
    logic       w_accept;
    t_gesture   w_gesture;
    t_action    w_kind;
    logic [7:0] w_index;

    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.contacts      <= i_in.contacts;
            r_in.pos_x         <= i_in.pos_x;
            r_in.pos_y         <= i_in.pos_y;
            r_in.time_ms       <= i_in.time_ms;
            r_in.overview_mode <= i_in.overview_mode;
            r_in.page_number   <= i_in.page_number;
            r_in.entry_count   <= i_in.entry_count;
        end
    end

    ttsc_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_advance),
        .i_sample (r_in),
        .o_gesture(w_gesture)
    );

    ttsc_classify u_classify (
        .i_sample (r_in),
        .i_gesture(w_gesture),
        .o_kind   (w_kind),
        .o_index  (w_index)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_kind  <= w_kind;
            r_index <= w_index;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.action_kind = r_kind;
    assign o_out.entry_index = r_index;

`ifndef NO_ASSERTIONS
    a_action_only_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_kind != ACT_NONE) |-> (r_in.contacts == 4'd0))
        else $error("action raised on a sample that is not a release");

    a_index_only_on_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.action_kind != ACT_SELECT) |-> (o_out.entry_index == 8'd0))
        else $error("entry index set without a select action");

    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("processed item did not reach the result register");

    a_release_clears_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in.contacts == 4'd0) |=> !w_gesture.pressed)
        else $error("release sample left the gesture pressed");
`endif

endmodule

/* test/tb_touch_tap_swipe_classifier_core.sv */
`timescale 1ns / 100ps

module tb_touch_tap_swipe_classifier_core;
    import ttsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 1350;
    localparam int HOLD_AT        = 500;
    localparam int LONG_HOLD      = 80;
    localparam int PRINT_CAP      = 50;

    class gesture_scoreboard;
        t_gesture   g;
        t_action    want_kind[$];
        logic [7:0] want_index[$];
        int         mismatches;
        int         checked;
        int         action_hits[5];

        function new();
            g = '0;
            mismatches = 0;
            checked = 0;
            foreach (action_hits[i]) action_hits[i] = 0;
        endfunction

        function logic [11:0] dist12(input logic [11:0] a, input logic [11:0] b);
            return (a > b) ? a - b : b - a;
        endfunction

        function int last_page(input logic [7:0] cnt);
            return (cnt == 8'd0) ? 0 : (int'(cnt) - 1) / ROWS_PER_PAGE;
        endfunction

        // hit-test of the press origin against the screen regions
        function void hit_test(input logic [11:0] x, input logic [11:0] y, input logic ov,
                               input logic [7:0] page, input logic [7:0] cnt,
                               output t_action kind, output logic [7:0] idx);
            int last;
            int row;
            int index;
            kind = ACT_NONE;
            idx = '0;
            if (x < 12 || x > 799 || y < 12 || y > 587) return;
            if (!ov) begin
                if (x >= 30 && x <= 630 && y <= 80 && cnt != 8'd0) kind = ACT_OPEN;
                return;
            end
            last = last_page(cnt);
            if (int'(page) > last) return;
            // page control: next on the left half, previous on the right
            if (cnt > 8'd3 && x >= 698 && x < 790 && y >= 538 && y < 584) begin
                if (x < 744 && int'(page) < last) kind = ACT_NEXT;
                if (x >= 744 && page > 8'd0) kind = ACT_PREV;
                return;
            end
            if (x > 787 || int'(y) < LIST_TOP_Y) return;
            row = (int'(y) - LIST_TOP_Y) / ROW_PITCH;
            index = int'(page) * ROWS_PER_PAGE + row;
            if (row < ROWS_PER_PAGE && index < int'(cnt)) begin
                kind = ACT_SELECT;
                idx = index[7:0];
            end
        endfunction

        function void note_sample(input t_sample s);
            t_action     kind;
            logic [7:0]  idx;
            logic [31:0] dur;
            logic [11:0] adx;
            logic [11:0] ady;
            logic [12:0] trav;
            kind = ACT_NONE;
            idx = '0;
            if (s.contacts != 4'd0) begin
                if (!g.pressed) begin
                    g.pressed = 1'b1;
                    g.aborted = 1'b0;
                    g.origin_x = s.pos_x;
                    g.origin_y = s.pos_y;
                    g.press_time = s.time_ms;
                    g.peak_travel = '0;
                end
                if (s.contacts != 4'd1) g.aborted = 1'b1;
                g.latest_x = s.pos_x;
                g.latest_y = s.pos_y;
                trav = 13'(dist12(s.pos_x, g.origin_x)) + 13'(dist12(s.pos_y, g.origin_y));
                if (trav > g.peak_travel) g.peak_travel = trav;
            end else if (g.pressed) begin
                g.pressed = 1'b0;
                dur = s.time_ms - g.press_time;
                if (!g.aborted && dur >= 32'd30 && dur <= 32'd2000) begin
                    adx = dist12(g.latest_x, g.origin_x);
                    ady = dist12(g.latest_y, g.origin_y);
                    if (s.overview_mode && ady >= 12'd45 && int'(ady) > 2 * int'(adx)) begin
                        if (g.latest_y < g.origin_y && int'(s.page_number) <
                                last_page(s.entry_count))
                            kind = ACT_NEXT;
                        if (g.latest_y > g.origin_y && s.page_number > 8'd0) kind = ACT_PREV;
                    end else if (g.peak_travel <= 13'd12 && dur <= 32'd700) begin
                        hit_test(g.origin_x, g.origin_y, s.overview_mode, s.page_number,
                                 s.entry_count, kind, idx);
                    end
                end
            end
            want_kind.push_back(kind);
            want_index.push_back(idx);
        endfunction

        task report(input string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_result(input logic [2:0] kind, input logic [7:0] idx);
            t_action    wk;
            logic [7:0] wi;
            if (want_kind.size() == 0) begin
                report($sformatf("unexpected result kind %0d index %0d", kind, idx));
                return;
            end
            wk = want_kind.pop_front();
            wi = want_index.pop_front();
            checked++;
            action_hits[int'(wk)]++;
            if (kind !== wk)
                report($sformatf("result %0d: action_kind %0d, want %0d", checked, kind, wk));
            if (idx !== wi)
                report($sformatf("result %0d: entry_index %0d, want %0d", checked, idx, wi));
        endtask

        function int pending();
            return want_kind.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ttsc_in_if  in_if();
    ttsc_out_if out_if();

    touch_tap_swipe_classifier_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    gesture_scoreboard sb = new();

    int          src_gap_max;
    int          dst_gap_max;
    int          sent;
    int          idle_cycles;
    logic [31:0] clock_ms;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_sample sample_of(input logic [3:0] c, input logic [11:0] x,
                                          input logic [11:0] y, input logic [31:0] t,
                                          input logic ov, input logic [7:0] pg,
                                          input logic [7:0] cnt);
        t_sample s;
        s.contacts = c;
        s.pos_x = x;
        s.pos_y = y;
        s.time_ms = t;
        s.overview_mode = ov;
        s.page_number = pg;
        s.entry_count = cnt;
        return s;
    endfunction

    function automatic logic [11:0] clamp12(input int v);
        if (v < 0) return 12'd0;
        if (v > 4095) return 12'd4095;
        return v[11:0];
    endfunction

    task automatic send_sample(input t_sample s);
        int gap;
        gap = $urandom_range(src_gap_max, 0);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.contacts <= s.contacts;
        in_if.pos_x <= s.pos_x;
        in_if.pos_y <= s.pos_y;
        in_if.time_ms <= s.time_ms;
        in_if.overview_mode <= s.overview_mode;
        in_if.page_number <= s.page_number;
        in_if.entry_count <= s.entry_count;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_sample(s);
        sent++;
    endtask

    // press at (x0,y0), optional stray point, move to (x1,y1), release after dur
    task automatic gesture(input logic [3:0] contacts, input logic [11:0] x0,
                           input logic [11:0] y0, input logic [11:0] x1, input logic [11:0] y1,
                           input logic ov, input logic [7:0] page, input logic [7:0] cnt,
                           input logic [31:0] dur, input bit wander);
        logic [31:0] t0;
        t0 = clock_ms;
        send_sample(sample_of(contacts, x0, y0, t0, 1'($urandom), 8'($urandom),
                              8'($urandom)));
        if (wander)
            send_sample(sample_of(4'd1, clamp12(int'(x0) + $urandom_range(40, 13)), y0,
                                  t0 + dur / 4, 1'($urandom), 8'($urandom), 8'($urandom)));
        if (wander || x1 != x0 || y1 != y0)
            send_sample(sample_of(4'd1, x1, y1, t0 + dur / 2, 1'($urandom), 8'($urandom),
                                  8'($urandom)));
        send_sample(sample_of(4'd0, 12'($urandom), 12'($urandom), t0 + dur, ov, page, cnt));
        clock_ms = t0 + dur + $urandom_range(3000, 1);
    endtask

    // result side
    initial begin
        int gap;
        int got;
        got = 0;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            // one long hold-off so the block backs up and stalls its input
            gap = (got == HOLD_AT) ? LONG_HOLD : $urandom_range(dst_gap_max, 0);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            sb.check_result(out_if.action_kind, out_if.entry_index);
            got++;
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int          r;
        int          lastp;
        int          dx;
        int          dy;
        int          noise;
        logic [3:0]  contacts;
        logic [11:0] x0;
        logic [11:0] y0;
        logic [11:0] x1;
        logic [11:0] y1;
        logic        ov;
        logic [7:0]  page;
        logic [7:0]  cnt;
        logic [31:0] dur;
        bit          wander;

        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.contacts <= '0;
        in_if.pos_x <= '0;
        in_if.pos_y <= '0;
        in_if.time_ms <= '0;
        in_if.overview_mode <= 1'b0;
        in_if.page_number <= '0;
        in_if.entry_count <= '0;
        sent = 0;
        noise = 0;
        src_gap_max = 2;
        dst_gap_max = 2;
        clock_ms = 32'd1000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // release with nothing pressed
        send_sample(sample_of(4'd0, 12'd400, 12'd300, clock_ms, 1'b1, 8'd0, 8'd20));
        // open in detail view
        gesture(4'd1, 12'd100, 12'd40, 12'd100, 12'd40, 1'b0, 8'd0, 8'd5, 32'd100, 1'b0);
        // select the third row, shortest duration
        gesture(4'd1, 12'd400, 12'd218, 12'd402, 12'd220, 1'b1, 8'd0, 8'd20, 32'd30, 1'b0);
        // page control, next half, longest tap
        gesture(4'd1, 12'd700, 12'd540, 12'd700, 12'd540, 1'b1, 8'd0, 8'd20, 32'd700, 1'b0);
        // page control, previous half on the last page
        gesture(4'd1, 12'd789, 12'd583, 12'd789, 12'd583, 1'b1, 8'd2, 8'd20, 32'd250, 1'b0);
        // upward swipe at the longest duration
        gesture(4'd1, 12'd400, 12'd500, 12'd400, 12'd300, 1'b1, 8'd0, 8'd255, 32'd2000,
                1'b0);
        // downward swipe on the first page has no page to turn
        gesture(4'd1, 12'd400, 12'd200, 12'd410, 12'd400, 1'b1, 8'd0, 8'd255, 32'd400, 1'b0);
        // many contacts abort the gesture
        gesture(4'd15, 12'd400, 12'd218, 12'd400, 12'd218, 1'b1, 8'd0, 8'd20, 32'd100, 1'b0);
        // timestamp that went backwards
        gesture(4'd1, 12'd100, 12'd40, 12'd100, 12'd40, 1'b0, 8'd0, 8'd5, 32'hFFFF_FFF6,
                1'b0);
        // page beyond the last page
        gesture(4'd1, 12'd400, 12'd218, 12'd400, 12'd218, 1'b1, 8'd5, 8'd8, 32'd100, 1'b0);
        // previous control on the first page is disabled
        gesture(4'd1, 12'd760, 12'd560, 12'd760, 12'd560, 1'b1, 8'd0, 8'd20, 32'd100, 1'b0);
        // tap on a row with no entry
        gesture(4'd1, 12'd400, 12'd377, 12'd400, 12'd377, 1'b1, 8'd0, 8'd3, 32'd100, 1'b0);
        // origin corner in detail view
        gesture(4'd1, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 8'd0, 8'd0, 32'd100, 1'b0);
        // far corner across the timestamp wrap
        clock_ms = 32'hFFFF_FFF0;
        gesture(4'd1, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, 8'd255, 8'd255, 32'd48,
                1'b0);

        while (sent < RANDOM_ITEMS + 30) begin
            case ((sent / 200) % 5)
                0: begin src_gap_max = 6; dst_gap_max = 6; end
                1: begin src_gap_max = 0; dst_gap_max = 0; end
                2: begin src_gap_max = 6; dst_gap_max = 0; end
                3: begin src_gap_max = 0; dst_gap_max = 6; end
                default: begin src_gap_max = 3; dst_gap_max = 3; end
            endcase

            if ($urandom_range(9, 0) == 0) begin
                // stray sample with every field random
                noise++;
                send_sample(sample_of(4'($urandom), 12'($urandom), 12'($urandom), $urandom,
                                      1'($urandom), 8'($urandom), 8'($urandom)));
            end else begin
                ov = ($urandom_range(3, 0) != 0);
                cnt = ($urandom_range(2, 0) == 0) ? 8'($urandom) : 8'($urandom_range(40, 0));
                lastp = (cnt == 8'd0) ? 0 : (int'(cnt) - 1) / ROWS_PER_PAGE;
                page = ($urandom_range(9, 0) == 0) ? 8'($urandom)
                                                   : 8'($urandom_range(lastp + 1, 0));
                contacts = ($urandom_range(9, 0) == 0) ? 4'($urandom_range(15, 2)) : 4'd1;

                r = $urandom_range(19, 0);
                if (r < 11)       dur = $urandom_range(700, 30);
                else if (r < 15)  dur = $urandom_range(2000, 701);
                else if (r < 16)  dur = $urandom_range(29, 0);
                else if (r < 17)  dur = $urandom_range(2100, 2001);
                else if (r < 18)  dur = $urandom;
                else begin
                    case ($urandom_range(5, 0))
                        0: dur = 32'd29;
                        1: dur = 32'd30;
                        2: dur = 32'd700;
                        3: dur = 32'd701;
                        4: dur = 32'd2000;
                        default: dur = 32'd2001;
                    endcase
                end

                r = $urandom_range(9, 0);
                if (r < 2) begin
                    x0 = 12'($urandom_range(640, 20));
                    y0 = 12'($urandom_range(90, 0));
                end else if (r < 4) begin
                    x0 = 12'($urandom_range(800, 690));
                    y0 = 12'($urandom_range(590, 530));
                end else if (r < 8) begin
                    x0 = 12'($urandom_range(800, 0));
                    y0 = 12'($urandom_range(600, 90));
                end else if (r < 9) begin
                    x0 = 12'($urandom);
                    y0 = 12'($urandom);
                end else begin
                    x0 = ($urandom_range(1, 0) != 0) ? 12'($urandom_range(20, 0))
                                                      : 12'($urandom_range(810, 780));
                    y0 = ($urandom_range(1, 0) != 0) ? 12'($urandom_range(20, 0))
                                                      : 12'($urandom_range(595, 575));
                end

                r = $urandom_range(9, 0);
                if (r < 5) begin
                    dx = $urandom_range(12, 0) - 6;
                    dy = $urandom_range(12, 0) - 6;
                end else if (r < 8) begin
                    dy = $urandom_range(400, 40);
                    dx = $urandom_range(dy / 2 + 5, 0);
                    if ($urandom_range(1, 0) != 0) dy = -dy;
                    if ($urandom_range(1, 0) != 0) dx = -dx;
                end else if (r < 9) begin
                    dx = $urandom_range(600, 0) - 300;
                    dy = $urandom_range(600, 0) - 300;
                end else begin
                    dx = 0;
                    dy = 0;
                end
                x1 = clamp12(int'(x0) + dx);
                y1 = clamp12(int'(y0) + dy);
                wander = ($urandom_range(9, 0) == 0);
                gesture(contacts, x0, y0, x1, y1, ov, page, cnt, dur, wander);
            end
        end

        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d samples (%0d stray), %0d results compared, one long output stall",
                 sent, noise, sb.checked);
        $display("actions: none %0d, open %0d, next %0d, prev %0d, select %0d",
                 sb.action_hits[0], sb.action_hits[1], sb.action_hits[2],
                 sb.action_hits[3], sb.action_hits[4]);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
